@@ rtl/core/fqs_pkg.sv @@
package fqs_pkg;

    // Number of words the queue can hold.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FN_ENQ     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_COUNT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DISPLAY = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] word;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         occupancy;
        logic                     last;
    } t_result;

endpackage

@@ rtl/core/fifo_queue_with_search.sv @@
// Bounded first-in first-out queue of signed 32-bit words with search.
//
// A command word (operation plus value) is taken on a rising edge where
// start is high and busy is low. Every command yields one result word on
// o_result, marked by o_valid for exactly one cycle; display of a non-empty
// queue yields one result word per stored entry, front to rear, with last
// set on the final one. The receiver cannot hold results off.
//
// Timing: enqueue, count, unknown operations and every operation on an
// empty queue answer on the cycle after acceptance and leave busy low, so
// such commands can be issued every cycle. Dequeue, peek, search and
// display walk the store one entry per cycle through a single registered
// read port and one 32-bit comparator: dequeue and peek read only the
// front entry, search stops at the first match or after the last entry,
// and display visits every entry. Busy is high only during that walk.
//
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the stored words themselves are not cleared.
module fifo_queue_with_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  fqs_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_valid,
    output fqs_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    // Registers and their next values.
    t_state                         r_state, n_state;
    logic [fqs_pkg::IDX_W-1:0]      r_head,  n_head;
    logic [fqs_pkg::IDX_W-1:0]      r_tail,  n_tail;
    logic [fqs_pkg::CNT_W-1:0]      r_count, n_count;
    logic [fqs_pkg::IDX_W-1:0]      r_ptr,   n_ptr;
    logic [fqs_pkg::CNT_W-1:0]      r_idx,   n_idx;
    fqs_pkg::t_cmd                  r_cmd,   n_cmd;
    logic                           r_valid, n_valid;
    fqs_pkg::t_result               r_result, n_result;
    logic signed [fqs_pkg::WORD_W-1:0] r_rdata;
    logic signed [fqs_pkg::WORD_W-1:0] r_mem [fqs_pkg::DEPTH];

    logic                           wr_en;
    logic [fqs_pkg::IDX_W-1:0]      rd_addr;
    logic [fqs_pkg::CNT_W-1:0]      idx_inc;
    logic                           last_entry;
    logic                           accept;

    function automatic logic [fqs_pkg::IDX_W-1:0] f_advance(
        input logic [fqs_pkg::IDX_W-1:0] i
    );
        if (i == fqs_pkg::IDX_W'(fqs_pkg::DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    function automatic fqs_pkg::t_result f_make(
        input logic [fqs_pkg::STAT_W-1:0]        status,
        input logic signed [fqs_pkg::WORD_W-1:0] word,
        input logic [fqs_pkg::CNT_W-1:0]         position,
        input logic [fqs_pkg::CNT_W-1:0]         occupancy,
        input logic                              last
    );
        fqs_pkg::t_result res;
        res.status    = status;
        res.word      = word;
        res.position  = fqs_pkg::POS_W'(position);
        res.occupancy = fqs_pkg::POS_W'(occupancy);
        res.last      = last;
        return res;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The walk counter tracks which entry, counted from the front, sits in
    // the read data register.
    assign idx_inc    = r_idx + 1'b1;
    assign last_entry = (idx_inc == r_count);

    // While idle the read port keeps fetching the front entry, so its data
    // is ready on the first walk cycle; during the walk it fetches ahead.
    assign rd_addr = (r_state == S_IDLE) ? r_head : f_advance(r_ptr);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_idx    = r_idx;
        n_cmd    = r_cmd;
        n_valid  = 1'b0;
        n_result = r_result;
        wr_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_ptr = r_head;
                    n_idx = '0;
                    unique case (i_cmd.func) inside
                        fqs_pkg::FN_ENQ: begin
                            n_valid = 1'b1;
                            if (r_count >= fqs_pkg::CNT_W'(fqs_pkg::DEPTH)) begin
                                n_result = f_make(fqs_pkg::ST_FULL, '0, '0, r_count, 1'b1);
                            end else begin
                                wr_en    = 1'b1;
                                n_tail   = f_advance(r_tail);
                                n_count  = r_count + 1'b1;
                                n_result = f_make(fqs_pkg::ST_OK, '0, '0, n_count, 1'b1);
                            end
                        end
                        fqs_pkg::FN_DEQ, fqs_pkg::FN_PEEK,
                        fqs_pkg::FN_SEARCH, fqs_pkg::FN_DISPLAY: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_result = f_make(fqs_pkg::ST_EMPTY, '0, '0, r_count, 1'b1);
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            // Count and unknown operations only report occupancy.
                            n_valid  = 1'b1;
                            n_result = f_make(fqs_pkg::ST_OK, '0, '0, r_count, 1'b1);
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_ptr = f_advance(r_ptr);
                n_idx = idx_inc;
                unique case (r_cmd.func)
                    fqs_pkg::FN_DEQ: begin
                        n_valid  = 1'b1;
                        n_head   = f_advance(r_head);
                        n_count  = r_count - 1'b1;
                        n_result = f_make(fqs_pkg::ST_OK, r_rdata, '0, n_count, 1'b1);
                        n_state  = S_IDLE;
                    end
                    fqs_pkg::FN_PEEK: begin
                        n_valid  = 1'b1;
                        n_result = f_make(fqs_pkg::ST_OK, r_rdata, '0, r_count, 1'b1);
                        n_state  = S_IDLE;
                    end
                    fqs_pkg::FN_SEARCH: begin
                        if (r_rdata == r_cmd.value) begin
                            n_valid  = 1'b1;
                            n_result = f_make(fqs_pkg::ST_OK, '0, idx_inc, r_count, 1'b1);
                            n_state  = S_IDLE;
                        end else if (last_entry) begin
                            n_valid  = 1'b1;
                            n_result = f_make(fqs_pkg::ST_NOTFOUND, '0, '0, r_count, 1'b1);
                            n_state  = S_IDLE;
                        end
                    end
                    fqs_pkg::FN_DISPLAY: begin
                        n_valid  = 1'b1;
                        n_result = f_make(fqs_pkg::ST_OK, r_rdata, '0, r_count, last_entry);
                        if (last_entry) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

    // Word store: one write port at the rear, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_cmd.value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // A result without last can only come from a display walk in progress.
    a_partial_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> r_state == S_WALK)
        else $error("non-final result outside a display walk");

    // The fill count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fqs_pkg::CNT_W'(fqs_pkg::DEPTH))
        else $error("fill count above depth");

    // An empty queue has its head and tail together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_head == r_tail)
        else $error("empty queue with head and tail apart");

    // A walk always ends with a result word.
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid && o_result.last)
        else $error("walk ended without a final result");

    // Enqueue and count answer on the very next cycle.
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.func == fqs_pkg::FN_ENQ || i_cmd.func == fqs_pkg::FN_COUNT)
        |=> o_valid && o_result.last && !busy)
        else $error("single-cycle operation did not answer at once");

endmodule
